@@ design/cdh_pkg.sv @@
// Package for the cylinder distance histogram: shared types, register codes and sizes.
// Used by the top level, the registers, the classifier and the update engine; depends on nothing.
`timescale 1ns / 1ps

package cdh_pkg;

  localparam int MOLECULES_DEF = 64;
  localparam int BINS_DEF      = 30;
  localparam int JOB_DEPTH     = 16;
  localparam int OUT_DEPTH     = 4;
  // Wide enough to hold any bin number up to the largest supported bin count.
  localparam int BIN_W         = 7;
  localparam int XY_W          = 43;
  localparam int DZ_W          = 21;

  typedef enum logic [2:0] {
    REG_REF_ONE    = 3'd0,
    REG_REF_TWO    = 3'd1,
    REG_REF_THREE  = 3'd2,
    REG_TOP_Z      = 3'd3,
    REG_BOTTOM_Z   = 3'd4,
    REG_ZERO_LIMIT = 3'd5,
    REG_STEP_WIDTH = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [39:0]        ref_one;
    logic [39:0]        ref_two;
    logic [39:0]        ref_three;
    logic signed [19:0] top_z;
    logic signed [19:0] bot_z;
    logic [18:0]        zero_limit;
    logic [18:0]        step_width;
  } cfg_t;

  // One histogram job from the classifier to the update engine.
  typedef struct packed {
    logic             mol_ok;
    logic             inc_en;
    logic             cnt_en;
    logic [5:0]       mol;
    logic [BIN_W-1:0] bin;
    logic [15:0]      frame;
  } job_t;

  typedef struct packed {
    logic        fresh;
    logic [16:0] first;
    logic [15:0] count;
    logic [4:0]  bin;
    logic [5:0]  mol;
  } res_t;

  localparam int JOB_W = $bits(job_t);
  localparam int RES_W = $bits(res_t);

endpackage

@@ design/cylinder_distance_histogram.sv @@
// Top level of the cylinder distance histogram: stream ports, APB registers and the
// classifier, job queue, update engine and output queue. Depends on cdh_pkg and submodules.
//
//  channel   handshake                       payload
//  s_axis    s_axis_tvalid / s_axis_tready   tdata atom fields, tuser command, tlast last atom
//  m_axis    m_axis_tvalid / m_axis_tready   tdata one result item
//  apb       psel, penable, pwrite / pready  paddr, pwdata, prdata
//
// One item is accepted every cycle while s_axis_tready is high.
// Reset starts a clearing pass over the MOLECULES*BINS entries (1920 by default) of the
// histogram memory; s_axis_tready stays low during it and while the threshold
// sweep runs after reset or a write of the zero limit or the step width.
// A stalled output fills the output queue and then the job queue, which lowers s_axis_tready.
`timescale 1ns / 1ps

module cylinder_distance_histogram #(
  parameter int MOLECULES = cdh_pkg::MOLECULES_DEF,
  parameter int BINS      = cdh_pkg::BINS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // molecule[5:0], bin_select[10:6], frame[26:11], pos_x[46:27], pos_y[66:47],
  // pos_z[86:67], zero[87]
  input  logic [87:0] s_axis_tdata,
  // command[0]
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_molecule[5:0], bin_index[10:6], bin_count[26:11], first association frame
  // plus one[43:27], newly_associated[44], zero[47:45]
  output logic [47:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int TW  = 19 + $clog2(BINS+1);
  localparam int JCW = $clog2(cdh_pkg::JOB_DEPTH+1);
  localparam int OCW = $clog2(cdh_pkg::OUT_DEPTH+1);

  cdh_pkg::cfg_t  cfg;
  logic            sweep_busy;
  logic            clear_busy;
  logic [2*TW-1:0] txy [BINS];
  logic [TW-1:0]   tz [BINS];
  logic            accept;
  logic [2:0]      inflight;
  logic            job_push;
  cdh_pkg::job_t   job_in;
  logic            job_valid;
  logic [cdh_pkg::JOB_W-1:0] job_raw;
  logic            job_pop;
  logic [JCW-1:0]  job_count;
  logic            res_push;
  cdh_pkg::res_t   res;
  logic [cdh_pkg::RES_W-1:0] res_head;
  logic [OCW-1:0]  out_count;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !sweep_busy && !clear_busy &&
                         (32'(job_count) + 32'(inflight) < cdh_pkg::JOB_DEPTH);

  cdh_regs #(.BINS(BINS), .TW(TW)) u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg, .sweep_busy, .txy, .tz
  );

  cdh_front #(.MOLECULES(MOLECULES), .BINS(BINS), .TW(TW)) u_front (
    .clk, .rst,
    .in_valid(accept),
    .in_cmd(s_axis_tuser),
    .in_last(s_axis_tlast),
    .in_mol(s_axis_tdata[5:0]),
    .in_sel(s_axis_tdata[10:6]),
    .in_frame(s_axis_tdata[26:11]),
    .in_x(s_axis_tdata[46:27]),
    .in_y(s_axis_tdata[66:47]),
    .in_z(s_axis_tdata[86:67]),
    .cfg, .txy, .tz, .inflight,
    .push(job_push), .job(job_in)
  );

  cdh_queue #(.W(cdh_pkg::JOB_W), .DEPTH(cdh_pkg::JOB_DEPTH)) u_job_q (
    .clk, .rst, .push(job_push), .push_data(job_in), .pop(job_pop),
    .head_valid(job_valid), .head_data(job_raw), .count(job_count)
  );

  cdh_back #(.MOLECULES(MOLECULES), .BINS(BINS)) u_back (
    .clk, .rst, .job_valid, .job(cdh_pkg::job_t'(job_raw)), .job_pop, .out_count,
    .res_push, .res, .clear_busy
  );

  cdh_queue #(.W(cdh_pkg::RES_W), .DEPTH(cdh_pkg::OUT_DEPTH)) u_out_q (
    .clk, .rst, .push(res_push), .push_data(res), .pop(m_axis_tvalid && m_axis_tready),
    .head_valid(m_axis_tvalid), .head_data(res_head), .count(out_count)
  );

  assign m_axis_tdata = {3'b000, res_head};

endmodule

@@ design/cdh_queue.sv @@
// Small register FIFO used between the classifier and the update engine and at the output.
// Depends on nothing.
`timescale 1ns / 1ps

module cdh_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [W-1:0]               push_data,
  input  logic                       pop,
  output logic                       head_valid,
  output logic [W-1:0]               head_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic          do_push;
  logic          do_pop;

  assign do_push    = push && (count != CW'(DEPTH));
  assign do_pop     = pop && (count != '0);
  assign head_valid = (count != '0);
  assign head_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

@@ design/cdh_regs.sv @@
// Configuration registers on the APB port and the bin threshold tables built from them.
// Depends on cdh_pkg.
`timescale 1ns / 1ps

module cdh_regs #(
  parameter int BINS = cdh_pkg::BINS_DEF,
  parameter int TW   = 19 + $clog2(BINS+1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [5:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  output cdh_pkg::cfg_t       cfg,
  output logic                sweep_busy,
  output logic [2*TW-1:0]     txy [BINS],
  output logic [TW-1:0]       tz [BINS]
);

  localparam int KW = $clog2(BINS);

  cdh_pkg::reg_idx_t idx;
  logic              wr;
  logic [KW-1:0]     sw_k;
  logic [TW-1:0]     sw_t;
  logic [TW-1:0]     sw_tz;
  logic [2*TW-1:0]   sw_sq;
  logic [18:0]       start_new;
  logic [18:0]       width_new;

  assign pready = 1'b1;
  assign idx    = cdh_pkg::reg_idx_t'(paddr[5:3]);
  assign wr     = psel && penable && pwrite;
  assign sw_sq  = sw_t * sw_t;

  assign start_new = (idx == cdh_pkg::REG_ZERO_LIMIT) ? pwdata[18:0] : cfg.zero_limit;
  assign width_new = (idx == cdh_pkg::REG_STEP_WIDTH) ? pwdata[18:0] : cfg.step_width;

  always_comb begin
    unique case (idx)
      cdh_pkg::REG_REF_ONE:    prdata = {24'd0, cfg.ref_one};
      cdh_pkg::REG_REF_TWO:    prdata = {24'd0, cfg.ref_two};
      cdh_pkg::REG_REF_THREE:  prdata = {24'd0, cfg.ref_three};
      cdh_pkg::REG_TOP_Z:      prdata = {44'd0, cfg.top_z};
      cdh_pkg::REG_BOTTOM_Z:   prdata = {44'd0, cfg.bot_z};
      cdh_pkg::REG_ZERO_LIMIT: prdata = {45'd0, cfg.zero_limit};
      cdh_pkg::REG_STEP_WIDTH: prdata = {45'd0, cfg.step_width};
      default:                 prdata = '0;
    endcase
  end

  // The tables hold s + k*w squared and (k+1)*w; a sweep rebuilds them entry by entry
  // after reset and after any write of the zero limit or the step width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg        <= '{step_width: 19'd256, default: '0};
      sweep_busy <= 1'b1;
      sw_k       <= '0;
      sw_t       <= '0;
      sw_tz      <= TW'(256);
    end else begin
      if (wr) begin
        unique case (idx)
          cdh_pkg::REG_REF_ONE:    cfg.ref_one    <= pwdata[39:0];
          cdh_pkg::REG_REF_TWO:    cfg.ref_two    <= pwdata[39:0];
          cdh_pkg::REG_REF_THREE:  cfg.ref_three  <= pwdata[39:0];
          cdh_pkg::REG_TOP_Z:      cfg.top_z      <= pwdata[19:0];
          cdh_pkg::REG_BOTTOM_Z:   cfg.bot_z      <= pwdata[19:0];
          cdh_pkg::REG_ZERO_LIMIT: cfg.zero_limit <= pwdata[18:0];
          cdh_pkg::REG_STEP_WIDTH: cfg.step_width <= pwdata[18:0];
          default: ;
        endcase
      end
      if (wr && (idx == cdh_pkg::REG_ZERO_LIMIT || idx == cdh_pkg::REG_STEP_WIDTH)) begin
        sweep_busy <= 1'b1;
        sw_k       <= '0;
        sw_t       <= TW'(start_new);
        sw_tz      <= TW'(width_new);
      end else if (sweep_busy) begin
        sw_k  <= sw_k + KW'(1);
        sw_t  <= sw_t + TW'(cfg.step_width);
        sw_tz <= sw_tz + TW'(cfg.step_width);
        if (sw_k == KW'(BINS-1)) begin
          sweep_busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sweep_busy) begin
      txy[sw_k] <= sw_sq;
      tz[sw_k]  <= sw_tz;
    end
  end

endmodule

@@ design/cdh_front.sv @@
// Classifier: distance pipeline, running minima per molecule run and bin selection.
// Depends on cdh_pkg; produces one job per read command or last atom.
`timescale 1ns / 1ps

module cdh_front #(
  parameter int MOLECULES = cdh_pkg::MOLECULES_DEF,
  parameter int BINS      = cdh_pkg::BINS_DEF,
  parameter int TW        = 19 + $clog2(BINS+1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_cmd,
  input  logic                in_last,
  input  logic [5:0]          in_mol,
  input  logic [4:0]          in_sel,
  input  logic [15:0]         in_frame,
  input  logic signed [19:0]  in_x,
  input  logic signed [19:0]  in_y,
  input  logic signed [19:0]  in_z,
  input  cdh_pkg::cfg_t       cfg,
  input  logic [2*TW-1:0]     txy [BINS],
  input  logic [TW-1:0]       tz [BINS],
  output logic [2:0]          inflight,
  output logic                push,
  output cdh_pkg::job_t       job
);

  localparam int XW = cdh_pkg::XY_W;
  localparam int ZW = cdh_pkg::DZ_W;
  localparam int CW = (2*TW > XW) ? 2*TW : XW;

  typedef struct packed {
    logic        cmd;
    logic        last;
    logic [5:0]  mol;
    logic [4:0]  sel;
    logic [15:0] frame;
  } meta_t;

  logic [6:0] vld;
  meta_t      md [7];

  logic signed [19:0] x0, y0, z0;
  logic signed [20:0] dx1 [3];
  logic signed [20:0] dy1 [3];
  logic signed [20:0] a1, b1;
  logic               o1;
  logic [41:0]        sqx2 [3];
  logic [41:0]        sqy2 [3];
  logic [ZW-1:0]      dz2;
  logic               o2;
  logic [XW-1:0]      sum3 [3];
  logic [ZW-1:0]      dz3;
  logic               o3;
  logic [XW-1:0]      d4;
  logic [ZW-1:0]      dz4;
  logic               o4;
  logic [XW-1:0]      acc_xy;
  logic [ZW-1:0]      acc_dz;
  logic               acc_out;
  logic [XW-1:0]      fxy5, fxy6;
  logic [ZW-1:0]      fdz5;
  logic               fo5, fo6;
  logic [BINS-1:0]    zv6, xv6;
  logic [2*ZW-1:0]    dzsq6;

  logic [39:0]        refs [3];
  logic signed [41:0] px [3];
  logic signed [41:0] py [3];
  logic [ZW-1:0]      abs_a, abs_b;
  logic [XW-1:0]      min01;
  logic [XW-1:0]      fold_xy;
  logic [ZW-1:0]      fold_dz;
  logic               fold_out;
  logic [2*ZW-1:0]    dzsq;
  logic               zbr;
  logic               mol_ok;
  logic [cdh_pkg::BIN_W-1:0] zbin, xbin, pbin;

  assign refs[0] = cfg.ref_one;
  assign refs[1] = cfg.ref_two;
  assign refs[2] = cfg.ref_three;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      px[i] = dx1[i] * dx1[i];
      py[i] = dy1[i] * dy1[i];
    end
    abs_a = a1[20] ? ZW'(-a1) : ZW'(a1);
    abs_b = b1[20] ? ZW'(-b1) : ZW'(b1);
    min01 = (sum3[1] < sum3[0]) ? sum3[1] : sum3[0];
    fold_xy  = (d4 < acc_xy) ? d4 : acc_xy;
    fold_dz  = (o4 && dz4 < acc_dz) ? dz4 : acc_dz;
    fold_out = acc_out | o4;
    dzsq     = fdz5 * fdz5;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      acc_xy  <= '1;
      acc_dz  <= '1;
      acc_out <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      vld[1] <= vld[0];
      vld[2] <= vld[1];
      vld[3] <= vld[2];
      vld[4] <= vld[3];
      // Only read commands and last atoms go on past the fold.
      vld[5] <= vld[4] && (md[4].cmd || md[4].last);
      vld[6] <= vld[5];
      if (vld[4] && !md[4].cmd) begin
        if (md[4].last) begin
          acc_xy  <= '1;
          acc_dz  <= '1;
          acc_out <= 1'b0;
        end else begin
          acc_xy  <= fold_xy;
          acc_dz  <= fold_dz;
          acc_out <= fold_out;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    md[0] <= '{cmd: in_cmd, last: in_last, mol: in_mol, sel: in_sel, frame: in_frame};
    x0    <= in_x;
    y0    <= in_y;
    z0    <= in_z;
    for (int i = 1; i < 7; i++) begin
      md[i] <= md[i-1];
    end

    for (int i = 0; i < 3; i++) begin
      dx1[i] <= 21'($signed(refs[i][19:0])) - 21'(x0);
      dy1[i] <= 21'($signed(refs[i][39:20])) - 21'(y0);
    end
    a1 <= 21'(z0) - 21'(cfg.top_z);
    b1 <= 21'(z0) - 21'(cfg.bot_z);
    o1 <= (z0 > cfg.top_z) || (z0 < cfg.bot_z);

    for (int i = 0; i < 3; i++) begin
      sqx2[i] <= unsigned'(px[i]);
      sqy2[i] <= unsigned'(py[i]);
    end
    dz2 <= (abs_a < abs_b) ? abs_a : abs_b;
    o2  <= o1;

    for (int i = 0; i < 3; i++) begin
      sum3[i] <= XW'(sqx2[i]) + XW'(sqy2[i]);
    end
    dz3 <= dz2;
    o3  <= o2;

    d4  <= (sum3[2] < min01) ? sum3[2] : min01;
    dz4 <= dz3;
    o4  <= o3;

    fxy5 <= fold_xy;
    fdz5 <= fold_dz;
    fo5  <= fold_out;

    for (int k = 0; k < BINS; k++) begin
      zv6[k] <= CW'(fdz5) <= CW'(tz[k]);
      xv6[k] <= CW'(fxy5) <= CW'(txy[k]);
    end
    dzsq6 <= dzsq;
    fxy6  <= fxy5;
    fo6   <= fo5;
  end

  always_comb begin
    zbr  = fo6 && (XW'(dzsq6) > fxy6);
    zbin = cdh_pkg::BIN_W'(BINS);
    for (int k = BINS-1; k >= 0; k--) begin
      if (zv6[k]) begin
        zbin = cdh_pkg::BIN_W'(k);
      end
    end
    xbin = cdh_pkg::BIN_W'(BINS-1);
    for (int k = BINS-2; k >= 0; k--) begin
      if (xv6[k]) begin
        xbin = cdh_pkg::BIN_W'(k);
      end
    end
    mol_ok = 32'(md[6].mol) < MOLECULES;
    pbin   = mol_ok ? (zbr ? zbin : xbin) : cdh_pkg::BIN_W'(BINS);

    job.mol_ok = mol_ok;
    job.mol    = md[6].mol;
    job.frame  = md[6].frame;
    if (md[6].cmd) begin
      job.bin    = cdh_pkg::BIN_W'(md[6].sel);
      job.inc_en = 1'b0;
      job.cnt_en = mol_ok && (32'(md[6].sel) < BINS);
    end else begin
      job.bin    = pbin;
      job.inc_en = mol_ok && (32'(pbin) < BINS);
      job.cnt_en = mol_ok && (32'(pbin) < BINS);
    end
  end

  assign push     = vld[6];
  assign inflight = 3'($countones(vld));

endmodule

@@ design/cdh_back.sv @@
// Update engine: histogram and first-frame memories, read-modify-write with forwarding.
// Depends on cdh_pkg; runs the clearing pass after reset.
`timescale 1ns / 1ps

module cdh_back #(
  parameter int MOLECULES = cdh_pkg::MOLECULES_DEF,
  parameter int BINS      = cdh_pkg::BINS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                job_valid,
  input  cdh_pkg::job_t                       job,
  output logic                                job_pop,
  input  logic [$clog2(cdh_pkg::OUT_DEPTH+1)-1:0] out_count,
  output logic                                res_push,
  output cdh_pkg::res_t                       res,
  output logic                                clear_busy
);

  localparam int HDEPTH = MOLECULES * BINS;
  localparam int HAW    = $clog2(HDEPTH);
  localparam int AAW    = (MOLECULES > 1) ? $clog2(MOLECULES) : 1;

  logic [15:0]     hist  [HDEPTH];
  logic [16:0]     assoc [MOLECULES];

  logic            rq_v;
  cdh_pkg::job_t   rq;
  logic [HAW-1:0]  rq_haddr;
  logic [AAW-1:0]  rq_aidx;
  logic [15:0]     hrd;
  logic [16:0]     ard;
  logic            fwd_h, fwd_a;
  logic [15:0]     fwd_hv;
  logic [16:0]     fwd_av;
  logic [HAW-1:0]  clr_idx;

  logic [HAW-1:0]  haddr;
  logic [AAW-1:0]  aidx;
  logic [15:0]     old_cnt, new_cnt;
  logic [16:0]     old_as, new_as;
  logic            fresh;

  assign haddr   = HAW'(32'(job.mol) * BINS + 32'(job.bin));
  assign aidx    = AAW'(job.mol);
  assign job_pop = job_valid && !clear_busy &&
                   (32'(out_count) + 32'(rq_v) < cdh_pkg::OUT_DEPTH);

  always_comb begin
    old_cnt = fwd_h ? fwd_hv : hrd;
    new_cnt = (rq.inc_en && old_cnt != 16'hFFFF) ? old_cnt + 16'd1 : old_cnt;
    old_as  = fwd_a ? fwd_av : ard;
    fresh   = rq.inc_en && (rq.bin == '0) && (old_as == '0);
    new_as  = fresh ? {1'b0, rq.frame} + 17'd1 : old_as;
  end

  assign res_push  = rq_v;
  assign res.mol   = rq.mol;
  assign res.bin   = rq.bin[4:0];
  assign res.count = rq.cnt_en ? new_cnt : 16'd0;
  assign res.first = rq.mol_ok ? new_as : 17'd0;
  assign res.fresh = fresh;

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_v       <= 1'b0;
      clear_busy <= 1'b1;
      clr_idx    <= '0;
    end else begin
      rq_v <= job_pop;
      if (clear_busy) begin
        clr_idx <= clr_idx + HAW'(1);
        if (clr_idx == HAW'(HDEPTH-1)) begin
          clear_busy <= 1'b0;
        end
      end
    end
  end

  // A job read in the same cycle as the write of the job ahead of it takes the new value.
  always_ff @(posedge clk) begin
    if (job_pop) begin
      rq       <= job;
      rq_haddr <= haddr;
      rq_aidx  <= aidx;
      hrd      <= hist[haddr];
      ard      <= assoc[aidx];
      fwd_h    <= rq_v && (rq_haddr == haddr);
      fwd_hv   <= new_cnt;
      fwd_a    <= rq_v && (rq_aidx == aidx);
      fwd_av   <= new_as;
    end
  end

  always_ff @(posedge clk) begin
    if (clear_busy) begin
      hist[clr_idx] <= '0;
    end else if (rq_v && rq.inc_en) begin
      hist[rq_haddr] <= new_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (clear_busy) begin
      if (32'(clr_idx) < MOLECULES) begin
        assoc[AAW'(clr_idx)] <= '0;
      end
    end else if (rq_v && fresh) begin
      assoc[rq_aidx] <= new_as;
    end
  end

endmodule

@@ design/cdh_checker.sv @@
// Port-level checks for the cylinder distance histogram, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module cdh_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  // The clearing pass keeps the input closed right after reset.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("input ready during clearing pass");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // A new association only comes from an increment of bin zero.
  a_fresh_bin0: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[44] |->
      m_axis_tdata[10:6] == 5'd0 && m_axis_tdata[26:11] != 16'd0 &&
      m_axis_tdata[43:27] != 17'd0)
    else $error("new association without a bin zero count");

endmodule

bind cylinder_distance_histogram cdh_checker u_cdh_checker (.*);

@@ verif/tb_top.sv @@
// Self-checking testbench for cylinder_distance_histogram: drives atom and read items over
// the stream input, programs the APB registers and checks every result with its own predictor.
// Depends on cdh_pkg and the RTL of the block.
`timescale 1ns / 1ps

class histogram_scoreboard;
  logic [39:0] ref_xy [3];
  logic signed [19:0] top_z, bot_z;
  logic [18:0] zero_limit, step_width;
  logic [42:0] min_xy_sq;
  logic [20:0] min_dz;
  bit outside;
  logic [15:0] hist [64*30];
  logic [16:0] assoc [64];
  cdh_pkg::res_t pending_results[$];
  int errors;

  function void reset_state();
    foreach (ref_xy[i]) ref_xy[i] = '0;
    top_z = '0;
    bot_z = '0;
    zero_limit = '0;
    step_width = 19'd256;
    clear_minima();
    foreach (hist[i]) hist[i] = '0;
    foreach (assoc[i]) assoc[i] = '0;
    errors = 0;
  endfunction

  function void clear_minima();
    min_xy_sq = '1;
    min_dz = '1;
    outside = 0;
  endfunction

  function void set_reg(cdh_pkg::reg_idx_t idx, logic [63:0] v);
    case (idx)
      cdh_pkg::REG_REF_ONE:    ref_xy[0] = v[39:0];
      cdh_pkg::REG_REF_TWO:    ref_xy[1] = v[39:0];
      cdh_pkg::REG_REF_THREE:  ref_xy[2] = v[39:0];
      cdh_pkg::REG_TOP_Z:      top_z = v[19:0];
      cdh_pkg::REG_BOTTOM_Z:   bot_z = v[19:0];
      cdh_pkg::REG_ZERO_LIMIT: zero_limit = v[18:0];
      cdh_pkg::REG_STEP_WIDTH: step_width = v[18:0];
      default: ;
    endcase
  endfunction

  function longint axis_dist_sq(logic [39:0] axis, longint x, longint y);
    longint dx, dy;
    dx = longint'($signed(axis[19:0])) - x;
    dy = longint'($signed(axis[39:20])) - y;
    return dx * dx + dy * dy;
  endfunction

  function int choose_bin();
    longint w, s, t, dz;
    w = longint'(step_width);
    s = longint'(zero_limit);
    dz = longint'(min_dz);
    if (outside && dz * dz > longint'(min_xy_sq)) begin
      for (int k = 0; k < 30; k++)
        if (dz <= (k + 1) * w) return k;
      return 30;
    end
    if (longint'(min_xy_sq) <= s * s) return 0;
    for (int k = 1; k < 29; k++) begin
      t = s + k * w;
      if (longint'(min_xy_sq) <= t * t) return k;
    end
    return 29;
  endfunction

  // Works out the result, if any, of one accepted input item.
  function void note_item(bit cmd, logic [5:0] mol, logic [4:0] sel, logic [15:0] frame,
                          logic signed [19:0] x, logic signed [19:0] y,
                          logic signed [19:0] z, bit last);
    cdh_pkg::res_t r;
    longint d2, t, za, ta, ba, a, b;
    int bin;
    r = '0;
    r.mol = mol;
    if (cmd) begin
      r.bin = sel;
      r.first = assoc[mol];
      if (sel < 30) r.count = hist[mol * 30 + sel];
      pending_results.push_back(r);
      return;
    end
    d2 = axis_dist_sq(ref_xy[0], x, y);
    for (int i = 1; i < 3; i++) begin
      t = axis_dist_sq(ref_xy[i], x, y);
      if (t < d2) d2 = t;
    end
    if (d2 < longint'(min_xy_sq)) min_xy_sq = d2[42:0];
    za = longint'(z);
    ta = longint'(top_z);
    ba = longint'(bot_z);
    if (za > ta || za < ba) begin
      a = za >= ta ? za - ta : ta - za;
      b = za >= ba ? za - ba : ba - za;
      if (b < a) a = b;
      outside = 1;
      if (a < longint'(min_dz)) min_dz = a[20:0];
    end
    if (!last) return;
    bin = choose_bin();
    r.bin = bin[4:0];
    if (bin < 30) begin
      if (hist[mol * 30 + bin] != 16'hFFFF) hist[mol * 30 + bin]++;
      r.count = hist[mol * 30 + bin];
      if (bin == 0 && assoc[mol] == 0) begin
        assoc[mol] = {1'b0, frame} + 17'd1;
        r.fresh = 1;
      end
    end
    r.first = assoc[mol];
    clear_minima();
    pending_results.push_back(r);
  endfunction

  function void check_result(cdh_pkg::res_t got);
    cdh_pkg::res_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result item: %h", got);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (got.mol != want.mol) begin
      $error("out_molecule: expected %0d, actual %0d", want.mol, got.mol);
      errors++;
    end
    if (got.bin != want.bin) begin
      $error("bin_index: expected %0d, actual %0d", want.bin, got.bin);
      errors++;
    end
    if (got.count != want.count) begin
      $error("bin_count: expected %0d, actual %0d", want.count, got.count);
      errors++;
    end
    if (got.first != want.first) begin
      $error("first association frame: expected %0d, actual %0d", want.first, got.first);
      errors++;
    end
    if (got.fresh != want.fresh) begin
      $error("newly_associated: expected %0d, actual %0d", want.fresh, got.fresh);
      errors++;
    end
  endfunction
endclass

module tb_top;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  // molecule[5:0], bin_select[10:6], frame[26:11], pos_x[46:27], pos_y[66:47],
  // pos_z[86:67], zero[87]
  logic [87:0] s_axis_tdata = '0;
  // command[0]
  logic        s_axis_tuser = 0;
  logic        s_axis_tlast = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  // out_molecule[5:0], bin_index[10:6], bin_count[26:11], first association frame
  // plus one[43:27], newly_associated[44], zero[47:45]
  logic [47:0] m_axis_tdata;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  histogram_scoreboard sb = new();
  bit no_idle = 0;

  cylinder_distance_histogram u_top (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk) begin
    m_axis_tready <= no_idle || ($urandom_range(99) >= 9);
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata[44:0]);
  end

  task automatic write_reg(cdh_pkg::reg_idx_t idx, logic [63:0] v);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 6'(8 * int'(idx));
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.set_reg(idx, v);
  endtask

  task automatic send_item(bit cmd, logic [5:0] mol, logic [4:0] sel, logic [15:0] frame,
                           logic [19:0] x, logic [19:0] y, logic [19:0] z, bit last);
    if (!no_idle && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {1'b0, z, y, x, frame, sel, mol};
    s_axis_tuser <= cmd;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(cmd, mol, sel, frame, x, y, z, last);
  endtask

  // Lets every result drain, then waits out items still inside the block.
  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [19:0] near(logic [19:0] c);
    if ($urandom_range(7) == 0) return 20'($urandom);
    return c + 20'($signed($urandom_range(0, 8192)) - 4096);
  endfunction

  // One molecule's atoms for one frame, mostly close to an axis or a slab plane.
  task automatic send_molecule();
    logic [5:0] mol;
    logic [15:0] frame;
    logic [39:0] axis;
    int n;
    mol = 6'($urandom);
    frame = 16'($urandom);
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      axis = sb.ref_xy[$urandom_range(2)];
      send_item(0, mol, 5'($urandom), frame, near(axis[19:0]), near(axis[39:20]),
                near($urandom_range(1) ? sb.top_z : sb.bot_z), i == n - 1);
    end
  endtask

  task automatic random_phase(int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(9))
        0: begin
          send_item(1, 6'($urandom), 5'($urandom), 16'($urandom), 20'($urandom),
                    20'($urandom), 20'($urandom), 1'($urandom_range(1)));
          sent++;
        end
        1: begin
          send_item(0, 6'($urandom), 5'($urandom), 16'($urandom), 20'($urandom),
                    20'($urandom), 20'($urandom), 1'($urandom_range(1)));
          sent++;
        end
        default: begin
          send_molecule();
          sent += 3;
        end
      endcase
    end
    drain();
  endtask

  initial begin
    sb.reset_state();
    repeat (6) @(posedge clk);
    rst <= 0;

    // Defaults: all axes at the origin, slab of zero thickness at z = 0.
    send_item(1, 6'd0, 5'd0, 16'd0, 20'd0, 20'd0, 20'd0, 0);
    send_item(0, 6'd1, 5'd0, 16'd7, 20'd0, 20'd0, 20'd0, 1);
    send_item(0, 6'd1, 5'd0, 16'd9, 20'd0, 20'd0, 20'd0, 1);
    send_item(0, 6'd2, 5'd0, 16'hFFFF, 20'd0, 20'd0, 20'd0, 1);
    send_item(0, 6'd3, 5'd0, 16'd1, 20'h7FFFF, 20'h7FFFF, 20'd0, 0);
    send_item(0, 6'd3, 5'd0, 16'd1, 20'h80000, 20'h80000, 20'd0, 1);
    // Above the slab with a short z distance, then one beyond thirty widths.
    send_item(0, 6'd4, 5'd0, 16'd2, 20'h7FFFF, 20'd0, 20'd300, 1);
    send_item(0, 6'd5, 5'd0, 16'd3, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 1);
    send_item(0, 6'd6, 5'd0, 16'd4, 20'h7FFFF, 20'd0, 20'h80000, 1);
    send_item(0, 6'd7, 5'd0, 16'd5, 20'd600, 20'd0, 20'd0, 0);
    send_item(0, 6'd7, 5'd0, 16'd5, 20'd300, 20'd0, 20'd0, 1);
    send_item(1, 6'd1, 5'd0, 16'd0, 20'd0, 20'd0, 20'd0, 0);
    send_item(1, 6'd3, 5'd29, 16'd0, 20'd0, 20'd0, 20'd0, 0);
    send_item(1, 6'd7, 5'd1, 16'd0, 20'd0, 20'd0, 20'd0, 0);
    send_item(1, 6'd2, 5'd30, 16'd0, 20'd0, 20'd0, 20'd0, 0);
    send_item(1, 6'd63, 5'd31, 16'hFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1);
    drain();
    random_phase(100);

    write_reg(cdh_pkg::REG_REF_ONE, {24'd0, 20'h01000, 20'h00800});
    write_reg(cdh_pkg::REG_REF_TWO, {24'd0, 20'hFF000, 20'h02000});
    write_reg(cdh_pkg::REG_REF_THREE, {24'd0, 20'h00400, 20'hFEC00});
    write_reg(cdh_pkg::REG_TOP_Z, 64'd2560);
    write_reg(cdh_pkg::REG_BOTTOM_Z, 64'hFFFFF600);
    write_reg(cdh_pkg::REG_ZERO_LIMIT, 64'd512);
    write_reg(cdh_pkg::REG_STEP_WIDTH, 64'd128);
    random_phase(150);

    // A long stretch with no idling on either side.
    no_idle = 1;
    write_reg(cdh_pkg::REG_STEP_WIDTH, 64'd1);
    write_reg(cdh_pkg::REG_ZERO_LIMIT, 64'd0);
    random_phase(100);
    no_idle = 0;

    write_reg(cdh_pkg::REG_REF_ONE, {24'd0, 20'h7FFFF, 20'h80000});
    write_reg(cdh_pkg::REG_REF_TWO, {24'd0, 20'h80000, 20'h7FFFF});
    write_reg(cdh_pkg::REG_REF_THREE, 64'hFF_FFFF_FFFF);
    write_reg(cdh_pkg::REG_TOP_Z, 64'h7FFFF);
    write_reg(cdh_pkg::REG_BOTTOM_Z, 64'h80000);
    write_reg(cdh_pkg::REG_ZERO_LIMIT, 64'h7FFFF);
    write_reg(cdh_pkg::REG_STEP_WIDTH, 64'h7FFFF);
    random_phase(100);

    write_reg(cdh_pkg::REG_TOP_Z, 64'd256);
    write_reg(cdh_pkg::REG_BOTTOM_Z, 64'd0);
    write_reg(cdh_pkg::REG_ZERO_LIMIT, 64'd64);
    write_reg(cdh_pkg::REG_STEP_WIDTH, 64'd0);
    random_phase(40);

    write_reg(cdh_pkg::REG_REF_ONE, 64'd0);
    write_reg(cdh_pkg::REG_STEP_WIDTH, 64'd2048);
    random_phase(100);

    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
